// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htc assertion failed");

// Next-cycle implication, checked outside reset.
`define HTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htc assertion failed");

`endif

// ===== rtl/htc_pkg.sv =====
// Types, constants and helpers for the humidity/temperature compensation block.
// No dependencies.
package htc_pkg;

  localparam int unsigned NumStages = 12;

  localparam logic [31:0] TempFineOffset = 32'd76800;
  localparam logic [31:0] HumMax         = 32'd419430400;
  localparam logic [31:0] HumBiasD       = 32'd2097152;
  localparam logic [31:0] HumRoundA      = 32'd16384;
  localparam logic [31:0] HumRoundE      = 32'd8192;
  localparam logic [31:0] HumBiasC       = 32'd32768;
  localparam logic [31:0] TempRound      = 32'd128;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAL_T1    = 3'd0,
    REG_CAL_T2    = 3'd1,
    REG_CAL_T3    = 3'd2,
    REG_CAL_H1    = 3'd3,
    REG_CAL_H2    = 3'd4,
    REG_CAL_H3    = 3'd5,
    REG_CAL_H4_H5 = 3'd6,
    REG_CAL_H6    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic        [16:0] humidity_q10;
  } out_item_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [23:0] h4h5;
    logic [7:0]  h6;
  } cal_regs_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

  // arithmetic right shift of a 32-bit two's complement word
  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

// ===== rtl/htc_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the compensation pipeline.
// Depends on htc_pkg.
module htc_pipe_ctrl import htc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_stall_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output pipe_ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] en;

  // a stage loads when it is empty or its successor loads too
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.en   = en;
  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

// ===== rtl/htc_tfine.sv =====
// Stages 0..2: raw temperature to fine temperature and humidity offset term.
// Depends on htc_pkg.
module htc_tfine import htc_pkg::*; (
  input  logic        clk_i,
  input  pipe_ctrl_t  ctrl_i,
  input  in_item_t    in_data_i,
  input  cal_regs_t   cal_i,
  output logic [31:0] fine_o,
  output logic [31:0] hv_o,
  output logic [15:0] adch_o
);

  logic [31:0] t1, t2, t3;
  logic [31:0] x1, dt;
  logic [31:0] p1_q, dd_q, var1_q, p2_q, fine_q, hv_q;
  logic [31:0] fine_d;
  logic [15:0] adch0_q, adch1_q, adch2_q;

  assign t1 = {16'b0, cal_i.t1};
  assign t2 = {{16{cal_i.t2[15]}}, cal_i.t2};
  assign t3 = {{16{cal_i.t3[15]}}, cal_i.t3};
  assign x1 = (32'(in_data_i.raw_temperature) >> 3) - (t1 << 1);
  assign dt = (32'(in_data_i.raw_temperature) >> 4) - t1;
  assign fine_d = var1_q + asr32(p2_q, 14);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      p1_q    <= x1 * t2;
      dd_q    <= dt * dt;
      adch0_q <= in_data_i.raw_humidity;
    end
    if (ctrl_i.en[1]) begin
      var1_q  <= asr32(p1_q, 11);
      p2_q    <= asr32(dd_q, 12) * t3;
      adch1_q <= adch0_q;
    end
    if (ctrl_i.en[2]) begin
      fine_q  <= fine_d;
      hv_q    <= fine_d - TempFineOffset;
      adch2_q <= adch1_q;
    end
  end

  assign fine_o = fine_q;
  assign hv_o   = hv_q;
  assign adch_o = adch2_q;

endmodule

// ===== rtl/htc_hum.sv =====
// Stages 3..11: temperature scaling and the humidity compensation chain.
// Depends on htc_pkg.
module htc_hum import htc_pkg::*; (
  input  logic        clk_i,
  input  pipe_ctrl_t  ctrl_i,
  input  cal_regs_t   cal_i,
  input  logic [31:0] fine_i,
  input  logic [31:0] hv_i,
  input  logic [15:0] adch_i,
  output out_item_t   out_data_o
);

  logic [31:0] h2, h3, h4, h5, h6, h1;
  logic [31:0] tv, hsum, g, hv_fin;
  logic [15:0] temp_d;
  logic [16:0] hum_d;

  logic [31:0] mh5_q, mb_q, mc_q, a_q, b_q, c_q, bc_q, dh_q, e_q, ae_q, ss_q, g1_q;
  logic [31:0] a5_q, a6_q, a7_q, ae9_q, ae10_q;
  logic [15:0] adch3_q;
  logic [15:0] temp3_q, temp4_q, temp5_q, temp6_q, temp7_q, temp8_q, temp9_q, temp10_q;
  out_item_t   out_q;

  assign h1 = {24'b0, cal_i.h1};
  assign h2 = {{16{cal_i.h2[15]}}, cal_i.h2};
  assign h3 = {24'b0, cal_i.h3};
  assign h4 = {{20{cal_i.h4h5[11]}}, cal_i.h4h5[11:0]};
  assign h5 = {{20{cal_i.h4h5[23]}}, cal_i.h4h5[23:12]};
  assign h6 = {{24{cal_i.h6[7]}}, cal_i.h6};

  // saturate (fine*5 + 128) >> 8 to a signed 16-bit value
  always_comb begin
    tv = asr32((fine_i << 2) + fine_i + TempRound, 8);
    if ($signed(tv) > 32'sd32767) begin
      temp_d = 16'h7fff;
    end else if ($signed(tv) < -32'sd32768) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = tv[15:0];
    end
  end

  assign hsum = (32'(adch3_q) << 14) - (h4 << 20) - mh5_q + HumRoundA;

  // final subtract, clamp to 0..HumMax, scale down by 4096
  always_comb begin
    g      = asr32(g1_q, 4);
    hv_fin = ae10_q - g;
    if (hv_fin[31]) begin
      hum_d = '0;
    end else if (hv_fin > HumMax) begin
      hum_d = HumMax[28:12];
    end else begin
      hum_d = hv_fin[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      mh5_q   <= h5 * hv_i;
      mb_q    <= hv_i * h6;
      mc_q    <= hv_i * h3;
      adch3_q <= adch_i;
      temp3_q <= temp_d;
    end
    if (ctrl_i.en[4]) begin
      a_q     <= asr32(hsum, 15);
      b_q     <= asr32(mb_q, 10);
      c_q     <= asr32(mc_q, 11) + HumBiasC;
      temp4_q <= temp3_q;
    end
    if (ctrl_i.en[5]) begin
      bc_q    <= b_q * c_q;
      a5_q    <= a_q;
      temp5_q <= temp4_q;
    end
    if (ctrl_i.en[6]) begin
      dh_q    <= (asr32(bc_q, 10) + HumBiasD) * h2;
      a6_q    <= a5_q;
      temp6_q <= temp5_q;
    end
    if (ctrl_i.en[7]) begin
      e_q     <= asr32(dh_q + HumRoundE, 14);
      a7_q    <= a6_q;
      temp7_q <= temp6_q;
    end
    if (ctrl_i.en[8]) begin
      ae_q    <= a7_q * e_q;
      temp8_q <= temp7_q;
    end
    if (ctrl_i.en[9]) begin
      ss_q    <= asr32(ae_q, 15) * asr32(ae_q, 15);
      ae9_q   <= ae_q;
      temp9_q <= temp8_q;
    end
    if (ctrl_i.en[10]) begin
      g1_q     <= asr32(ss_q, 7) * h1;
      ae10_q   <= ae9_q;
      temp10_q <= temp9_q;
    end
    if (ctrl_i.en[11]) begin
      out_q.temperature_centi <= temp10_q;
      out_q.humidity_q10      <= hum_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/humidity_temperature_compensation.sv =====
// Top level of the humidity/temperature compensation block.
// Depends on htc_pkg, htc_pipe_ctrl, htc_tfine and htc_hum.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out      source     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item enters per cycle unless the pipe backs up behind an output stall;
// the multiply chain has twelve register stages.
// Each stage holds at most three 32x32 multiplies with short adds or shifts.
// Reset clears all valid bits and sets every calibration register to zero.
// A stall on the output freezes only the full stages behind it; empty stages
// keep filling, so input stall rises only when the whole pipe is backed up.
// The cfg channel is always ready; write calibration only while idle.
module humidity_temperature_compensation import htc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  // calibration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cal_regs_t   cal_q;
  cal_regs_t   cal_d;
  pipe_ctrl_t  ctrl;
  logic [31:0] fine;
  logic [31:0] hv;
  logic [15:0] adch;

  assign cfg_ready_o = 1'b1;

  // Decode a calibration write; drop bits above each register's width.
  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CAL_T1:    cal_d.t1   = cfg_data_i[15:0];
        REG_CAL_T2:    cal_d.t2   = cfg_data_i[15:0];
        REG_CAL_T3:    cal_d.t3   = cfg_data_i[15:0];
        REG_CAL_H1:    cal_d.h1   = cfg_data_i[7:0];
        REG_CAL_H2:    cal_d.h2   = cfg_data_i[15:0];
        REG_CAL_H3:    cal_d.h3   = cfg_data_i[7:0];
        REG_CAL_H4_H5: cal_d.h4h5 = cfg_data_i;
        REG_CAL_H6:    cal_d.h6   = cfg_data_i[7:0];
        default: begin
          cal_d = cal_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  // Valid bits and load enables for all twelve stages.
  htc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  // Stages 0..2: fine temperature.
  htc_tfine u_tfine (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .in_data_i (in_data_i),
    .cal_i     (cal_q),
    .fine_o    (fine),
    .hv_o      (hv),
    .adch_o    (adch)
  );

  // Stages 3..11: temperature output and humidity chain.
  htc_hum u_hum (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .cal_i      (cal_q),
    .fine_i     (fine),
    .hv_i       (hv),
    .adch_i     (adch),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/htc_checker.sv =====
// Port-level checks for the compensation block, bound to the top level.
// Depends on htc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module htc_checker import htc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_item_t           out_data_o
);

  // hold a stalled result
  `HTC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `HTC_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  // input backs up only behind a stalled, full output
  `HTC_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // humidity stays within its clamp
  `HTC_ASSERT_IMP(a_hum_range, clk_i, rst_ni, out_valid_o, out_data_o.humidity_q10 <= 17'd102400)

endmodule

bind humidity_temperature_compensation htc_checker u_htc_checker (.*);
